### rtl/core/dcts_pkg.sv
`default_nettype none

package dcts_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STEP_SIZE  = 3'd0;
    localparam logic [2:0] CFG_RATE_A     = 3'd1;
    localparam logic [2:0] CFG_RATE_B     = 3'd2;
    localparam logic [2:0] CFG_RATE_C     = 3'd3;
    localparam logic [2:0] CFG_TOLERANCE  = 3'd4;
    localparam logic [2:0] CFG_ITER_LIMIT = 3'd5;

    // Command codes carried on s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Serial arithmetic unit geometry.
    localparam int OPA_W     = 64;
    localparam int OPB_W     = 48;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int DIVD_W    = 95;
    localparam int MUL_STEPS = OPB_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = 7;

    localparam logic signed [63:0] SMAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic start;
        logic op_div;
    } dcts_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dcts_stat_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > SMAX65) begin
            return SMAX;
        end else if (s < -SMAX65) begin
            return -SMAX;
        end
        return 64'(s);
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
        logic signed [63:0] v;
        v = m[63] ? SMAX : $signed(m);
        return neg ? -v : v;
    endfunction

    // (|x| * k) >> 32, saturated, with the sign of x.
    function automatic logic signed [63:0] mulk_result(input logic [PROD_W-1:0] prod,
                                                       input logic neg);
        if (|prod[PROD_W-1:95]) begin
            return neg ? -SMAX : SMAX;
        end
        return with_sign({1'b0, prod[94:32]}, neg);
    endfunction

    // Unsigned population, zero extended to 64 bits, as a signed value.
    function automatic logic signed [63:0] pop_in(input logic [63:0] p);
        return p[63] ? SMAX : $signed(p);
    endfunction

endpackage

`default_nettype wire

### rtl/core/dcts_serial_unit.sv
`default_nettype none

module dcts_serial_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dcts_pkg::dcts_req_t            req,
    input  wire logic [dcts_pkg::OPA_W-1:0]     opa,
    input  wire logic [dcts_pkg::OPB_W-1:0]     opb,
    output dcts_pkg::dcts_stat_t                stat,
    output logic [dcts_pkg::PROD_W-1:0]         prod,
    output logic [63:0]                         quot
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          div_reg, div_next;
    logic [dcts_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [dcts_pkg::OPA_W-1:0]    a_reg, a_next;
    logic [dcts_pkg::OPB_W-1:0]    g_reg, g_next;
    logic [dcts_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [dcts_pkg::OPB_W-1:0]    rem_reg, rem_next;
    logic [dcts_pkg::DIVD_W-1:0]   dq_reg, dq_next;
    logic [dcts_pkg::OPA_W:0]      psum;
    logic [dcts_pkg::OPB_W:0]      trial;
    logic [dcts_pkg::OPB_W:0]      diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        g_next    = g_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        psum  = {1'b0, prod_reg[dcts_pkg::PROD_W-1:dcts_pkg::OPB_W]} + {1'b0, a_reg};
        trial = {rem_reg, dq_reg[dcts_pkg::DIVD_W-1]};
        diff  = trial - {1'b0, g_reg};
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            div_next  = req.op_div;
            a_next    = opa;
            g_next    = opb;
            if (req.op_div) begin
                cnt_next = dcts_pkg::CNT_W'(dcts_pkg::DIV_STEPS);
                rem_next = '0;
                dq_next  = {opa[62:0], 32'd0};
            end else begin
                cnt_next  = dcts_pkg::CNT_W'(dcts_pkg::MUL_STEPS);
                prod_next = {{dcts_pkg::OPA_W{1'b0}}, opb};
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                // Restoring division, one quotient bit per cycle.
                if (!diff[dcts_pkg::OPB_W]) begin
                    rem_next = diff[dcts_pkg::OPB_W-1:0];
                    dq_next  = {dq_reg[dcts_pkg::DIVD_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[dcts_pkg::OPB_W-1:0];
                    dq_next  = {dq_reg[dcts_pkg::DIVD_W-2:0], 1'b0};
                end
            end else begin
                // Shift-add multiplication, one multiplier bit per cycle.
                if (prod_reg[0]) begin
                    prod_next = {psum, prod_reg[dcts_pkg::OPB_W-1:1]};
                end else begin
                    prod_next = {1'b0, prod_reg[dcts_pkg::PROD_W-1:1]};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == dcts_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        div_reg  <= div_next;
        a_reg    <= a_next;
        g_reg    <= g_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = prod_reg;
    assign quot      = dq_reg[63:0];

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start) else $error("start while unit busy");
    a_done_follows_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg) else $error("done without work");
    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !div_reg) |-> cnt_reg <= dcts_pkg::CNT_W'(dcts_pkg::MUL_STEPS))
        else $error("multiply count out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/decay_chain_trapezoid_stepper_unit.sv
// Decay chain stepper for A -> B -> C. A word with s_tuser = 0 loads the three
// populations from s_tdata and returns them unchanged; a word with s_tuser = 1
// advances them by one implicit trapezoid-rule step solved by Newton iteration,
// and returns the new populations, the iteration count and a converged flag.
// Every multiply and divide goes through one shared bit-serial unit, one operand
// bit per cycle. A step first forms the three rate products, then runs Newton
// iterations of five multiplies, three divides, three residual states and one
// update state each, until it converges or reaches the iteration limit. A load
// goes from acceptance straight to the done state. The done state waits until
// the output register is free and then raises the result. One word is worked
// on at a time; s_tready is high only while the block is idle, which it is again
// in the same cycle that the result is raised. Configuration is written through
// cfg_* and is always accepted; it should only be changed while the block is
// idle.
`default_nettype none

module decay_chain_trapezoid_stepper_unit #(
    parameter int POP_WIDTH = 48
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write channel.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [31:0]               cfg_data,
    // Input stream.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // s_tdata: load_a, load_b, load_c (lowest bits first), zero padded.
    input  wire logic [((3*POP_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser: command (0 = load, 1 = step).
    input  wire logic                      s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // m_tdata: pop_a, pop_b, pop_c, iterations_used, converged, zero padded.
    output logic [((3*POP_WIDTH+7+7)/8)*8-1:0] m_tdata
);

    localparam int M_TDATA_W = ((3*POP_WIDTH+7+7)/8)*8;
    localparam logic [63:0] POP_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POP_WIDTH);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_K_GO   = 5'd1;
    localparam logic [4:0] ST_K_WAIT = 5'd2;
    localparam logic [4:0] ST_P_GO   = 5'd3;
    localparam logic [4:0] ST_P_WAIT = 5'd4;
    localparam logic [4:0] ST_F_A    = 5'd5;
    localparam logic [4:0] ST_F_B    = 5'd6;
    localparam logic [4:0] ST_F_C    = 5'd7;
    localparam logic [4:0] ST_D_GO   = 5'd8;
    localparam logic [4:0] ST_D_WAIT = 5'd9;
    localparam logic [4:0] ST_M_GO   = 5'd10;
    localparam logic [4:0] ST_M_WAIT = 5'd11;
    localparam logic [4:0] ST_UPD    = 5'd12;
    localparam logic [4:0] ST_DONE   = 5'd13;

    // Configuration registers.
    logic [31:0] step_reg;
    logic [31:0] rate_reg [3];
    logic [15:0] tol_reg;
    logic [5:0]  limit_reg;

    logic [4:0]  state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic        neg_reg, neg_next;
    logic [5:0]  iters_reg, iters_next;
    logic        conv_reg, conv_next;
    logic [POP_WIDTH-1:0] pop_reg [3];
    logic [POP_WIDTH-1:0] nw_reg [3];
    logic [POP_WIDTH-1:0] nw_next [3];
    logic [47:0]          k_reg [3];
    logic [47:0]          k_next [3];
    logic signed [63:0]   p_reg [3];
    logic signed [63:0]   p_next [3];
    logic signed [63:0]   f_reg [3];
    logic signed [63:0]   f_next [3];
    logic signed [63:0]   d_reg [3];
    logic signed [63:0]   d_next [3];
    logic signed [63:0]   t_reg, t_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 pop_load;

    logic signed [63:0]   o_val [3];
    logic signed [63:0]   n_val [3];
    logic [POP_WIDTH-1:0] upd_val [3];
    logic [63:0]          dmag [3];
    logic signed [63:0]   upd_sum [3];
    logic signed [63:0]   opx;
    logic [63:0]          eps;

    dcts_pkg::dcts_req_t  unit_req;
    dcts_pkg::dcts_stat_t unit_stat;
    logic [dcts_pkg::OPA_W-1:0]  unit_a;
    logic [dcts_pkg::OPB_W-1:0]  unit_b;
    logic [dcts_pkg::PROD_W-1:0] unit_prod;
    logic [63:0]                 unit_quot;

    dcts_serial_unit u_serial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .opa     (unit_a),
        .opb     (unit_b),
        .stat    (unit_stat),
        .prod    (unit_prod),
        .quot    (unit_quot)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 32'd65536;
            rate_reg[0] <= '0;
            rate_reg[1] <= '0;
            rate_reg[2] <= '0;
            tol_reg     <= '0;
            limit_reg   <= 6'd50;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dcts_pkg::CFG_STEP_SIZE:  step_reg    <= cfg_data;
                dcts_pkg::CFG_RATE_A:     rate_reg[0] <= cfg_data;
                dcts_pkg::CFG_RATE_B:     rate_reg[1] <= cfg_data;
                dcts_pkg::CFG_RATE_C:     rate_reg[2] <= cfg_data;
                dcts_pkg::CFG_TOLERANCE:  tol_reg     <= cfg_data[15:0];
                dcts_pkg::CFG_ITER_LIMIT: limit_reg   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Old and current estimates as signed values, the update of each population by
    // its correction clamped to the population range, and the largest correction size.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_val[i]   = dcts_pkg::pop_in(64'(pop_reg[i]));
            n_val[i]   = dcts_pkg::pop_in(64'(nw_reg[i]));
            upd_sum[i] = dcts_pkg::sat_add(n_val[i], d_reg[i]);
            dmag[i]    = dcts_pkg::mag(d_reg[i]);
            if (upd_sum[i][63]) begin
                upd_val[i] = '0;
            end else if ($unsigned(upd_sum[i]) > POP_MASK) begin
                upd_val[i] = POP_WIDTH'(POP_MASK);
            end else begin
                upd_val[i] = POP_WIDTH'($unsigned(upd_sum[i]));
            end
        end
        eps = dmag[0];
        if (dmag[1] > eps) begin
            eps = dmag[1];
        end
        if (dmag[2] > eps) begin
            eps = dmag[2];
        end
    end

    // Signed operand for the P, D and M launches, and the request and operands for the serial unit.
    always_comb begin
        unique case (state_reg)
            ST_P_GO: opx = dcts_pkg::sat_add(o_val[idx_reg], n_val[idx_reg]);
            ST_M_GO: opx = d_reg[idx_reg];
            ST_D_GO: opx = (idx_reg == 2'd0) ? -f_reg[0]
                                             : dcts_pkg::sat_add(-f_reg[idx_reg], t_reg);
            default: opx = '0;
        endcase
        unit_req.start  = (state_reg == ST_K_GO) || (state_reg == ST_P_GO) ||
                          (state_reg == ST_M_GO) || (state_reg == ST_D_GO);
        unit_req.op_div = (state_reg == ST_D_GO);
        if (state_reg == ST_K_GO) begin
            unit_a = 64'(rate_reg[idx_reg]);
            unit_b = 48'(step_reg);
        end else if (state_reg == ST_D_GO) begin
            unit_a = dcts_pkg::mag(opx);
            unit_b = 48'h1_0000_0000 + k_reg[idx_reg];
        end else begin
            unit_a = dcts_pkg::mag(opx);
            unit_b = k_reg[idx_reg];
        end
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        neg_next      = neg_reg;
        iters_next    = iters_reg;
        conv_next     = conv_reg;
        nw_next       = nw_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        f_next        = f_reg;
        d_next        = d_reg;
        t_next        = t_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pop_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    iters_next = '0;
                    conv_next  = 1'b1;
                    idx_next   = '0;
                    if (s_tuser == dcts_pkg::CMD_LOAD) begin
                        nw_next[0] = s_tdata[POP_WIDTH-1:0];
                        nw_next[1] = s_tdata[2*POP_WIDTH-1:POP_WIDTH];
                        nw_next[2] = s_tdata[3*POP_WIDTH-1:2*POP_WIDTH];
                        state_next = ST_DONE;
                    end else begin
                        nw_next    = pop_reg;
                        state_next = ST_K_GO;
                    end
                end
            end
            ST_K_GO: state_next = ST_K_WAIT;
            ST_K_WAIT: begin
                if (unit_stat.done) begin
                    k_next[idx_reg] = unit_prod[64:17];
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = ST_P_GO;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_K_GO;
                    end
                end
            end
            ST_P_GO: begin
                neg_next   = opx[63];
                state_next = ST_P_WAIT;
            end
            ST_P_WAIT: begin
                if (unit_stat.done) begin
                    p_next[idx_reg] = dcts_pkg::mulk_result(unit_prod, neg_reg);
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = ST_F_A;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_P_GO;
                    end
                end
            end
            ST_F_A: begin
                for (int i = 0; i < 3; i++) begin
                    f_next[i] = dcts_pkg::sat_add(n_val[i], -o_val[i]);
                end
                state_next = ST_F_B;
            end
            ST_F_B: begin
                f_next[0]  = dcts_pkg::sat_add(f_reg[0], p_reg[0]);
                f_next[1]  = dcts_pkg::sat_add(f_reg[1], -p_reg[0]);
                f_next[2]  = dcts_pkg::sat_add(f_reg[2], -p_reg[1]);
                state_next = ST_F_C;
            end
            ST_F_C: begin
                f_next[1]  = dcts_pkg::sat_add(f_reg[1], p_reg[1]);
                f_next[2]  = dcts_pkg::sat_add(f_reg[2], p_reg[2]);
                idx_next   = '0;
                state_next = ST_D_GO;
            end
            ST_D_GO: begin
                neg_next   = opx[63];
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT: begin
                if (unit_stat.done) begin
                    d_next[idx_reg] = dcts_pkg::with_sign(unit_quot, neg_reg);
                    state_next = (idx_reg == 2'd2) ? ST_UPD : ST_M_GO;
                end
            end
            ST_M_GO: begin
                neg_next   = opx[63];
                state_next = ST_M_WAIT;
            end
            ST_M_WAIT: begin
                if (unit_stat.done) begin
                    t_next     = dcts_pkg::mulk_result(unit_prod, neg_reg);
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_D_GO;
                end
            end
            ST_UPD: begin
                nw_next    = upd_val;
                iters_next = iters_reg + 6'd1;
                conv_next  = (eps <= 64'(tol_reg));
                idx_next   = '0;
                if ((eps <= 64'(tol_reg)) || (iters_next >= limit_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_P_GO;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    pop_load      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            pop_reg[0]   <= '0;
            pop_reg[1]   <= '0;
            pop_reg[2]   <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
            if (pop_load) begin
                pop_reg <= nw_reg;
            end
        end
        neg_reg   <= neg_next;
        iters_reg <= iters_next;
        conv_reg  <= conv_next;
        nw_reg    <= nw_next;
        k_reg     <= k_next;
        p_reg     <= p_next;
        f_reg     <= f_next;
        d_reg     <= d_next;
        t_reg     <= t_next;
    end

    // The result word is taken from the registers that are committed to the
    // population state in the same cycle that the word is raised.
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (pop_load) begin
            m_tdata_reg <= M_TDATA_W'({conv_reg, iters_reg, nw_reg[2], nw_reg[1], nw_reg[0]});
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !unit_stat.busy) else $error("unit busy while idle");
    a_fail_has_iters: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[3*POP_WIDTH+6]) |-> (m_tdata[3*POP_WIDTH+5:3*POP_WIDTH] != 6'd0))
        else $error("non-converged result without iterations");
    a_wait_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_K_GO) || (state_reg == ST_P_GO) || (state_reg == ST_D_GO) ||
         (state_reg == ST_M_GO)) |=> unit_stat.busy) else $error("launch did not start unit");
`endif

endmodule

`default_nettype wire

### bench/dcts_checker.sv
`timescale 1ns / 100ps

module dcts_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [143:0] s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [151:0] m_tdata,
    output int                errors,
    output int                pending
);

    typedef logic signed [63:0] s64_t;

    typedef struct packed {
        logic [47:0] pop_a;
        logic [47:0] pop_b;
        logic [47:0] pop_c;
        logic [5:0]  iters;
        logic        conv;
    } chain_result_t;

    localparam s64_t               BIG      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] BIG65    = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0]        FULL_POP = 48'hFFFF_FFFF_FFFF;

    logic [31:0] dt_q, ka_rate, kb_rate, kc_rate;
    logic [15:0] tol_q;
    logic [5:0]  limit_q;
    logic [47:0] chain [3];
    chain_result_t expected_q [$];

    initial errors = 0;
    initial pending = 0;

    function automatic s64_t clip_add(input s64_t a, input s64_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > BIG65) return BIG;
        if (s < -BIG65) return -BIG;
        return s[63:0];
    endfunction

    function automatic logic [63:0] abs64(input s64_t x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic s64_t signed_of(input logic [63:0] m, input logic neg);
        s64_t v;
        v = m[63] ? BIG : $signed(m);
        return neg ? -v : v;
    endfunction

    // Scale by a Q16.32 coefficient, truncating toward zero.
    function automatic s64_t scale_k(input s64_t x, input logic [63:0] k);
        logic [127:0] p;
        p = ({64'b0, abs64(x)} * {64'b0, k}) >> 32;
        if (|p[127:63]) return x[63] ? -BIG : BIG;
        return signed_of(p[63:0], x[63]);
    endfunction

    // Divide by g = 1 + k in Q.32, truncating toward zero.
    function automatic s64_t divide_g(input s64_t x, input logic [63:0] g);
        logic [127:0] q;
        q = {abs64(x), 32'b0} / {64'b0, g};
        return signed_of(q[63:0], x[63]);
    endfunction

    function automatic logic [47:0] clamp_pop(input s64_t n, input s64_t d);
        s64_t v;
        v = clip_add(n, d);
        if (v < 0) return 48'd0;
        if (v > s64_t'({16'b0, FULL_POP})) return FULL_POP;
        return v[47:0];
    endfunction

    function automatic chain_result_t advance_chain(input logic cmd, input logic [143:0] d);
        chain_result_t r;
        logic [63:0] k [3];
        logic [63:0] g [3];
        logic [31:0] rates [3];
        s64_t o [3];
        s64_t n [3];
        s64_t p [3];
        s64_t f [3];
        s64_t dl [3];
        logic [63:0] worst;
        int iters;
        r.conv = 1'b1;
        iters = 0;
        if (cmd == dcts_pkg::CMD_LOAD) begin
            chain[0] = d[47:0];
            chain[1] = d[95:48];
            chain[2] = d[143:96];
        end else begin
            rates[0] = ka_rate;
            rates[1] = kb_rate;
            rates[2] = kc_rate;
            for (int i = 0; i < 3; i++) begin
                k[i] = ({32'b0, dt_q} * {32'b0, rates[i]}) >> 17;
                g[i] = 64'h1_0000_0000 + k[i];
                o[i] = $signed({16'b0, chain[i]});
            end
            do begin
                for (int i = 0; i < 3; i++) begin
                    n[i] = $signed({16'b0, chain[i]});
                    p[i] = scale_k(clip_add(o[i], n[i]), k[i]);
                end
                f[0] = clip_add(clip_add(n[0], -o[0]), p[0]);
                f[1] = clip_add(clip_add(clip_add(n[1], -o[1]), -p[0]), p[1]);
                f[2] = clip_add(clip_add(clip_add(n[2], -o[2]), -p[1]), p[2]);
                dl[0] = divide_g(-f[0], g[0]);
                dl[1] = divide_g(clip_add(-f[1], scale_k(dl[0], k[0])), g[1]);
                dl[2] = divide_g(clip_add(-f[2], scale_k(dl[1], k[1])), g[2]);
                iters++;
                worst = 0;
                for (int i = 0; i < 3; i++) begin
                    chain[i] = clamp_pop(n[i], dl[i]);
                    if (abs64(dl[i]) > worst) worst = abs64(dl[i]);
                end
            end while (worst > {48'b0, tol_q} && iters < limit_q);
            r.conv = worst <= {48'b0, tol_q};
        end
        r.pop_a = chain[0];
        r.pop_b = chain[1];
        r.pop_c = chain[2];
        r.iters = iters[5:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        chain_result_t e;
        if (!aresetn) begin
            dt_q <= 32'd65536;
            ka_rate <= '0;
            kb_rate <= '0;
            kc_rate <= '0;
            tol_q <= '0;
            limit_q <= 6'd50;
            chain[0] = '0;
            chain[1] = '0;
            chain[2] = '0;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dcts_pkg::CFG_STEP_SIZE:  dt_q <= cfg_data;
                    dcts_pkg::CFG_RATE_A:     ka_rate <= cfg_data;
                    dcts_pkg::CFG_RATE_B:     kb_rate <= cfg_data;
                    dcts_pkg::CFG_RATE_C:     kc_rate <= cfg_data;
                    dcts_pkg::CFG_TOLERANCE:  tol_q <= cfg_data[15:0];
                    dcts_pkg::CFG_ITER_LIMIT: limit_q <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_q.push_back(advance_chain(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result word %0h arrived with nothing expected", m_tdata);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("pop_a", e.pop_a, m_tdata[47:0]);
                    check_field("pop_b", e.pop_b, m_tdata[95:48]);
                    check_field("pop_c", e.pop_c, m_tdata[143:96]);
                    check_field("iterations_used", e.iters, m_tdata[149:144]);
                    check_field("converged", e.conv, m_tdata[150]);
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

### bench/tb_decay_chain_trapezoid_stepper_unit.sv
`timescale 1ns / 100ps

module tb_decay_chain_trapezoid_stepper_unit;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // s_tdata: load_a [47:0], load_b [95:48], load_c [143:96].
    logic [143:0] s_tdata = '0;
    // s_tuser: command.
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // m_tdata: pop_a, pop_b, pop_c, iterations_used, converged, zero padded.
    logic [151:0] m_tdata;

    int errors;
    int pending;

    // When set, neither side idles between words.
    logic steady = 1'b0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    logic hold_req = 1'b0;
    int   loads_sent = 0;
    int   steps_sent = 0;
    int   settings = 0;

    localparam int HOLD_CYCLES = 2500;

    decay_chain_trapezoid_stepper_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    dcts_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // The slowest legal run is far below this: a few directed steps at the full
    // iteration limit, the rest at a limit of five or less, plus idling and one
    // long hold-off.
    initial begin
        #200_000_000;
        $display("tb_decay_chain_trapezoid_stepper_unit: errors");
        $finish;
    end

    // Result side. Each word gets a random stall unless the phase is steady;
    // once per run it holds off long enough that the block backs up its input.
    initial begin
        int gap;
        repeat (13) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Valid is left high after a handshake so that a back-to-back word never
    // drops and raises it in the same step; a gap lowers it first.
    task automatic send_word(input logic cmd, input logic [47:0] a, input logic [47:0] b,
                             input logic [47:0] c);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {c, b, a};
        do @(posedge aclk); while (!s_tready);
        if (cmd == dcts_pkg::CMD_LOAD) loads_sent++;
        else steps_sent++;
    endtask

    // Step words carry junk in the data field, which the block must ignore.
    task automatic send_step();
        send_word(dcts_pkg::CMD_STEP, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Every word returns a result, so the block is idle once nothing is pending.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        settings++;
    endtask

    function automatic logic [47:0] pick_pop();
        case ($urandom_range(0, 5))
            0: return 48'd0;
            1: return 48'hFFFF_FFFF_FFFF;
            2: return 48'($urandom_range(0, 1 << 20));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] value;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. With reset settings a step is the identity.
        send_step();
        send_word(dcts_pkg::CMD_LOAD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF);
        send_step();
        send_word(dcts_pkg::CMD_LOAD, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'd0);
        drain();

        // Largest step and rates, full limit. Wide writes must be masked, so the
        // tolerance ends up zero and the limit 63.
        write_reg(dcts_pkg::CFG_STEP_SIZE, 32'hFFFF_FFFF);
        write_reg(dcts_pkg::CFG_RATE_A, 32'hFFFF_FFFF);
        write_reg(dcts_pkg::CFG_RATE_B, 32'hFFFF_FFFF);
        write_reg(dcts_pkg::CFG_RATE_C, 32'hFFFF_FFFF);
        write_reg(dcts_pkg::CFG_TOLERANCE, 32'hABCD_0000);
        write_reg(dcts_pkg::CFG_ITER_LIMIT, 32'hFFFF_FFFF);
        send_word(dcts_pkg::CMD_LOAD, 48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555,
                  48'hAAAA_AAAA_AAAA);
        send_step();
        send_step();
        drain();

        // A limit of zero still runs one iteration.
        write_reg(dcts_pkg::CFG_ITER_LIMIT, 32'h0000_0040);
        write_reg(dcts_pkg::CFG_STEP_SIZE, 32'd65536);
        write_reg(dcts_pkg::CFG_RATE_A, 32'h8000_0000);
        write_reg(dcts_pkg::CFG_RATE_B, 32'h4000_0000);
        write_reg(dcts_pkg::CFG_RATE_C, 32'h2000_0000);
        send_word(dcts_pkg::CMD_LOAD, 48'h0100_0000_0000, 48'd12345, 48'd0);
        send_step();
        drain();

        // The only allowed iteration meets a wide tolerance: converged stays set.
        write_reg(dcts_pkg::CFG_ITER_LIMIT, 32'd1);
        write_reg(dcts_pkg::CFG_TOLERANCE, 32'h1234_FFFF);
        send_word(dcts_pkg::CMD_LOAD, 48'd1000, 48'd2000, 48'd3000);
        send_step();
        drain();

        // Writes beyond the register list change nothing.
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0000_0000);
        write_reg(dcts_pkg::CFG_TOLERANCE, 32'd0);
        write_reg(dcts_pkg::CFG_ITER_LIMIT, 32'd63);
        send_word(dcts_pkg::CMD_LOAD, 48'h0000_4000_0000, 48'h0000_0100_0000, 48'd7);
        send_step();
        send_step();
        send_step();
        drain();

        // A zero time step leaves the populations alone.
        write_reg(dcts_pkg::CFG_STEP_SIZE, 32'd0);
        send_step();
        send_word(dcts_pkg::CMD_LOAD, 48'd0, 48'd0, 48'd0);
        send_step();
        drain();

        // Random phases: a new setting, then a run of loads and steps.
        for (int phase = 0; phase < 13; phase++) begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                1: value = 32'd65536;
                2: value = $urandom;
                default: value = $urandom_range(1, 1 << 20);
            endcase
            write_reg(dcts_pkg::CFG_STEP_SIZE, value);
            write_reg(dcts_pkg::CFG_RATE_A, pick_rate());
            write_reg(dcts_pkg::CFG_RATE_B, pick_rate());
            write_reg(dcts_pkg::CFG_RATE_C, pick_rate());
            case ($urandom_range(0, 2))
                0: value = 32'd0;
                1: value = $urandom_range(0, 65535);
                default: value = $urandom_range(0, 15);
            endcase
            write_reg(dcts_pkg::CFG_TOLERANCE, {16'($urandom_range(0, 65535)), value[15:0]});
            value = $urandom_range(0, 5);
            write_reg(dcts_pkg::CFG_ITER_LIMIT,
                      {26'($urandom_range(0, (1 << 26) - 1)), value[5:0]});
            if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(6, 7)), $urandom);
            if (phase == 3) hold_req = 1'b1;
            for (int n = 0; n < 110; n++) begin
                if ($urandom_range(0, 9) < 4) send_word(dcts_pkg::CMD_LOAD, pick_pop(),
                                                        pick_pop(), pick_pop());
                else send_step();
            end
            drain();
        end

        steady = 1'b0;
        repeat (50) @(posedge aclk);
        $display("Covered %0d load words and %0d step words across %0d register settings,",
                 loads_sent, steps_sent, settings);
        $display("with random stalls on both sides and one %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb_decay_chain_trapezoid_stepper_unit: clean");
        end else begin
            $display("tb_decay_chain_trapezoid_stepper_unit: errors");
        end
        $finish;
    end

endmodule
